FILE: hw/rtl/sts_pkg.sv
// Shared types, character codes and helper functions for the shell token scanner.
package sts_pkg;

  // Position counter width and width of the position fields on the result port
  localparam int POS_BITS = 16;
  localparam int OUT_W    = 16;

  // Result queue depth; one byte may push two tokens
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  typedef logic [POS_BITS-1:0] pos_t;
  typedef logic [OUT_W-1:0]    out_pos_t;
  typedef logic [PTR_W-1:0]    ptr_t;
  typedef logic [CNT_W-1:0]    cnt_t;

  localparam pos_t POS_MAX = '1;
  localparam pos_t POS_ONE = pos_t'(1);

  // Character codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_Z  = 8'h7A;
  localparam logic [7:0] CH_PIPE   = 8'h7C;

  // Token being collected across bytes
  typedef enum logic [2:0] {
    PEND_NONE,
    PEND_NAME,
    PEND_DIGITS,
    PEND_OP,
    PEND_DLESS
  } pend_t;

  // Token kinds on the result port
  typedef enum logic [4:0] {
    TK_NEWLINE   = 5'd0,
    TK_WORD      = 5'd1,
    TK_ASSIGN    = 5'd2,
    TK_IONUM     = 5'd3,
    TK_SEMI      = 5'd4,
    TK_LPAREN    = 5'd5,
    TK_RPAREN    = 5'd6,
    TK_AND_IF    = 5'd7,
    TK_OR_IF     = 5'd8,
    TK_DLESS     = 5'd9,
    TK_DLESSDASH = 5'd10,
    TK_DGREAT    = 5'd11,
    TK_LESSAND   = 5'd12,
    TK_GREATAND  = 5'd13,
    TK_LESSGREAT = 5'd14,
    TK_CLOBBER   = 5'd15,
    TK_PIPE      = 5'd16,
    TK_AMP       = 5'd17,
    TK_LESS      = 5'd18,
    TK_GREAT     = 5'd19
  } kind_t;

  typedef struct packed {
    kind_t    kind;
    out_pos_t span_start;
    out_pos_t span_end;
    out_pos_t start_row;
    out_pos_t start_column;
    logic     last;
  } tok_t;

  typedef struct packed {
    logic valid;
    tok_t tok;
  } tok_slot_t;

  function automatic pos_t sat_inc(input pos_t v);
    return (v == POS_MAX) ? v : v + POS_ONE;
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= CH_LOW_A) && (c <= CH_LOW_Z)) || ((c >= CH_UP_A) && (c <= CH_UP_Z));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_opchar(input logic [7:0] c);
    return (c == CH_PIPE) || (c == CH_AMP) || (c == CH_LT) || (c == CH_GT);
  endfunction

  function automatic kind_t single_op_kind(input logic [7:0] c);
    kind_t k;
    case (c)
      CH_PIPE: k = TK_PIPE;
      CH_AMP:  k = TK_AMP;
      CH_LT:   k = TK_LESS;
      CH_GT:   k = TK_GREAT;
      default: k = TK_WORD;
    endcase
    return k;
  endfunction

  function automatic tok_t make_tok(input kind_t k, input pos_t s, input pos_t e,
                                    input pos_t r, input pos_t col);
    tok_t t;
    t.kind         = k;
    t.span_start   = out_pos_t'(s);
    t.span_end     = out_pos_t'(e);
    t.start_row    = out_pos_t'(r);
    t.start_column = out_pos_t'(col);
    t.last         = 1'b0;
    return t;
  endfunction

endpackage

FILE: hw/rtl/sts_byte_if.sv
// Handshake channel carrying one source text byte per transfer.
interface sts_byte_if ();
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink (input valid, input text_byte, output ready);
endinterface

FILE: hw/rtl/sts_token_if.sv
// Handshake channel carrying one token record per transfer.
interface sts_token_if ();
  logic        valid;
  logic        ready;
  logic [4:0]  token_kind;
  logic [15:0] span_start;
  logic [15:0] span_end;
  logic [15:0] start_row;
  logic [15:0] start_column;
  logic        last_of_run;

  modport source (output valid, output token_kind, output span_start, output span_end,
                  output start_row, output start_column, output last_of_run, input ready);
  modport sink (input valid, input token_kind, input span_start, input span_end,
                input start_row, input start_column, input last_of_run, output ready);
endinterface

FILE: hw/rtl/sts_lexer.sv
// Scanner state and per-byte token logic: closes a pending token and starts a new one.
module sts_lexer (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  logic [7:0]        byte_in,
  output sts_pkg::tok_slot_t res_a,
  output sts_pkg::tok_slot_t res_b
);

  sts_pkg::pend_t pend, pend_next;
  logic [7:0]     first_op_char, first_op_char_next;
  sts_pkg::pos_t  token_offset, token_offset_next;
  sts_pkg::pos_t  token_row, token_row_next;
  sts_pkg::pos_t  token_column, token_column_next;
  sts_pkg::pos_t  cur_offset, cur_offset_next;
  sts_pkg::pos_t  cur_row, cur_row_next;
  sts_pkg::pos_t  cur_column, cur_column_next;

  sts_pkg::pos_t  off_inc;
  sts_pkg::pos_t  row_step;
  sts_pkg::pos_t  col_step;
  logic           word_char;
  logic           is_ws;
  logic           pair_hit;
  sts_pkg::kind_t pair_kind;
  logic           consumed;
  sts_pkg::tok_slot_t slot_a, slot_b;

  // Position after this byte is taken
  always_comb begin
    off_inc = sts_pkg::sat_inc(cur_offset);
    if (byte_in == sts_pkg::CH_NL) begin
      row_step = sts_pkg::sat_inc(cur_row);
      col_step = sts_pkg::POS_ONE;
    end else begin
      row_step = cur_row;
      col_step = sts_pkg::sat_inc(cur_column);
    end
    word_char = sts_pkg::is_alpha(byte_in) || sts_pkg::is_digit(byte_in) ||
                (byte_in == sts_pkg::CH_UNDER);
    is_ws = (byte_in == sts_pkg::CH_SPACE) || (byte_in == sts_pkg::CH_TAB) ||
            (byte_in == sts_pkg::CH_CR);
  end

  // Match the two-character operators
  always_comb begin
    pair_hit  = 1'b1;
    pair_kind = sts_pkg::TK_WORD;
    if (first_op_char == sts_pkg::CH_AMP && byte_in == sts_pkg::CH_AMP) begin
      pair_kind = sts_pkg::TK_AND_IF;
    end else if (first_op_char == sts_pkg::CH_PIPE && byte_in == sts_pkg::CH_PIPE) begin
      pair_kind = sts_pkg::TK_OR_IF;
    end else if (first_op_char == sts_pkg::CH_LT && byte_in == sts_pkg::CH_LT) begin
      pair_kind = sts_pkg::TK_DLESS;
    end else if (first_op_char == sts_pkg::CH_GT && byte_in == sts_pkg::CH_GT) begin
      pair_kind = sts_pkg::TK_DGREAT;
    end else if (first_op_char == sts_pkg::CH_LT && byte_in == sts_pkg::CH_AMP) begin
      pair_kind = sts_pkg::TK_LESSAND;
    end else if (first_op_char == sts_pkg::CH_GT && byte_in == sts_pkg::CH_AMP) begin
      pair_kind = sts_pkg::TK_GREATAND;
    end else if (first_op_char == sts_pkg::CH_LT && byte_in == sts_pkg::CH_GT) begin
      pair_kind = sts_pkg::TK_LESSGREAT;
    end else if (first_op_char == sts_pkg::CH_GT && byte_in == sts_pkg::CH_PIPE) begin
      pair_kind = sts_pkg::TK_CLOBBER;
    end else begin
      pair_hit = 1'b0;
    end
  end

  // Close the pending token, then start a token from the byte if it was not absorbed
  always_comb begin
    pend_next          = pend;
    first_op_char_next = first_op_char;
    token_offset_next  = token_offset;
    token_row_next     = token_row;
    token_column_next  = token_column;
    cur_offset_next    = cur_offset;
    cur_row_next       = cur_row;
    cur_column_next    = cur_column;
    consumed           = 1'b0;
    slot_a.valid       = 1'b0;
    slot_a.tok         = sts_pkg::make_tok(sts_pkg::TK_WORD, token_offset, cur_offset,
                                           token_row, token_column);
    slot_b.valid       = 1'b0;
    slot_b.tok         = sts_pkg::make_tok(sts_pkg::TK_WORD, cur_offset, off_inc,
                                           cur_row, cur_column);

    if (byte_in == sts_pkg::CH_NUL) begin
      // End of text: flush pending token, restart all positions
      case (pend)
        sts_pkg::PEND_NAME, sts_pkg::PEND_DIGITS: begin
          slot_a.valid = 1'b1;
        end
        sts_pkg::PEND_OP: begin
          slot_a.valid    = 1'b1;
          slot_a.tok.kind = sts_pkg::single_op_kind(first_op_char);
        end
        sts_pkg::PEND_DLESS: begin
          slot_a.valid    = 1'b1;
          slot_a.tok.kind = sts_pkg::TK_DLESS;
        end
        default: begin
          slot_a.valid = 1'b0;
        end
      endcase
      pend_next          = sts_pkg::PEND_NONE;
      first_op_char_next = sts_pkg::CH_NUL;
      token_offset_next  = '0;
      token_row_next     = sts_pkg::POS_ONE;
      token_column_next  = sts_pkg::POS_ONE;
      cur_offset_next    = '0;
      cur_row_next       = sts_pkg::POS_ONE;
      cur_column_next    = sts_pkg::POS_ONE;
    end else begin
      case (pend)
        sts_pkg::PEND_NAME: begin
          if (word_char) begin
            consumed = 1'b1;
          end else begin
            slot_a.valid    = 1'b1;
            slot_a.tok.kind = (byte_in == sts_pkg::CH_EQ) ? sts_pkg::TK_ASSIGN
                                                          : sts_pkg::TK_WORD;
          end
        end
        sts_pkg::PEND_DIGITS: begin
          if (sts_pkg::is_digit(byte_in)) begin
            consumed = 1'b1;
          end else begin
            slot_a.valid    = 1'b1;
            slot_a.tok.kind = (byte_in == sts_pkg::CH_LT || byte_in == sts_pkg::CH_GT)
                              ? sts_pkg::TK_IONUM : sts_pkg::TK_WORD;
          end
        end
        sts_pkg::PEND_OP: begin
          if (pair_hit) begin
            consumed = 1'b1;
            if (pair_kind != sts_pkg::TK_DLESS) begin
              slot_a.valid        = 1'b1;
              slot_a.tok.kind     = pair_kind;
              slot_a.tok.span_end = sts_pkg::out_pos_t'(off_inc);
            end
          end else begin
            slot_a.valid    = 1'b1;
            slot_a.tok.kind = sts_pkg::single_op_kind(first_op_char);
          end
        end
        sts_pkg::PEND_DLESS: begin
          slot_a.valid = 1'b1;
          if (byte_in == sts_pkg::CH_MINUS) begin
            consumed            = 1'b1;
            slot_a.tok.kind     = sts_pkg::TK_DLESSDASH;
            slot_a.tok.span_end = sts_pkg::out_pos_t'(off_inc);
          end else begin
            slot_a.tok.kind = sts_pkg::TK_DLESS;
          end
        end
        default: begin
          consumed = 1'b0;
        end
      endcase

      // Pending kind after the close or the extension
      if (consumed) begin
        if (pend == sts_pkg::PEND_OP && pair_kind == sts_pkg::TK_DLESS) begin
          pend_next = sts_pkg::PEND_DLESS;
        end else if (pend == sts_pkg::PEND_OP || pend == sts_pkg::PEND_DLESS) begin
          pend_next = sts_pkg::PEND_NONE;
        end
      end else begin
        pend_next = sts_pkg::PEND_NONE;
      end

      // Every byte but end of text advances the position
      cur_offset_next = off_inc;
      cur_row_next    = row_step;
      cur_column_next = col_step;

      // Fresh byte: mark token start and classify
      if (!consumed && !is_ws) begin
        token_offset_next = cur_offset;
        token_row_next    = cur_row;
        token_column_next = cur_column;
        if (byte_in == sts_pkg::CH_NL) begin
          slot_b.valid    = 1'b1;
          slot_b.tok.kind = sts_pkg::TK_NEWLINE;
        end else if (sts_pkg::is_alpha(byte_in) || byte_in == sts_pkg::CH_UNDER) begin
          pend_next = sts_pkg::PEND_NAME;
        end else if (sts_pkg::is_digit(byte_in)) begin
          pend_next = sts_pkg::PEND_DIGITS;
        end else if (sts_pkg::is_opchar(byte_in)) begin
          pend_next          = sts_pkg::PEND_OP;
          first_op_char_next = byte_in;
        end else if (byte_in == sts_pkg::CH_SEMI) begin
          slot_b.valid    = 1'b1;
          slot_b.tok.kind = sts_pkg::TK_SEMI;
        end else if (byte_in == sts_pkg::CH_LPAREN) begin
          slot_b.valid    = 1'b1;
          slot_b.tok.kind = sts_pkg::TK_LPAREN;
        end else if (byte_in == sts_pkg::CH_RPAREN) begin
          slot_b.valid    = 1'b1;
          slot_b.tok.kind = sts_pkg::TK_RPAREN;
        end else begin
          slot_b.valid    = 1'b1;
          slot_b.tok.kind = sts_pkg::TK_WORD;
        end
      end
    end

    // Flag the final token of this byte
    slot_b.tok.last = slot_b.valid;
    slot_a.tok.last = slot_a.valid && !slot_b.valid;
  end

  assign res_a = slot_a;
  assign res_b = slot_b;

  // Advance scanner state on each processed byte
  always_ff @(posedge clk) begin
    if (rst) begin
      pend          <= sts_pkg::PEND_NONE;
      first_op_char <= sts_pkg::CH_NUL;
      token_offset  <= '0;
      token_row     <= sts_pkg::POS_ONE;
      token_column  <= sts_pkg::POS_ONE;
      cur_offset    <= '0;
      cur_row       <= sts_pkg::POS_ONE;
      cur_column    <= sts_pkg::POS_ONE;
    end else if (fire) begin
      pend          <= pend_next;
      first_op_char <= first_op_char_next;
      token_offset  <= token_offset_next;
      token_row     <= token_row_next;
      token_column  <= token_column_next;
      cur_offset    <= cur_offset_next;
      cur_row       <= cur_row_next;
      cur_column    <= cur_column_next;
    end
  end

endmodule

FILE: hw/rtl/sts_fifo.sv
// Small token queue that takes up to two tokens per cycle and delivers one.
module sts_fifo (
  input  logic               clk,
  input  logic               rst,
  input  sts_pkg::tok_slot_t push_a,
  input  sts_pkg::tok_slot_t push_b,
  output logic               room,
  output logic               head_valid,
  output sts_pkg::tok_t      head,
  input  logic               pop
);

  sts_pkg::tok_t mem [sts_pkg::FIFO_DEPTH];
  sts_pkg::ptr_t wr_ptr, rd_ptr;
  sts_pkg::cnt_t count, count_next;
  sts_pkg::ptr_t addr_b;
  logic          do_pop;

  assign do_pop     = pop && (count != '0);
  assign addr_b     = push_a.valid ? wr_ptr + sts_pkg::ptr_t'(1) : wr_ptr;
  assign room       = count <= sts_pkg::cnt_t'(sts_pkg::FIFO_DEPTH - 2);
  assign head_valid = count != '0;
  assign head       = mem[rd_ptr];

  always_comb begin
    count_next = count + sts_pkg::cnt_t'(push_a.valid) + sts_pkg::cnt_t'(push_b.valid)
                 - sts_pkg::cnt_t'(do_pop);
  end

  // Store incoming tokens in arrival order
  always_ff @(posedge clk) begin
    if (push_a.valid) begin
      mem[wr_ptr] <= push_a.tok;
    end
    if (push_b.valid) begin
      mem[addr_b] <= push_b.tok;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + sts_pkg::ptr_t'(push_a.valid) + sts_pkg::ptr_t'(push_b.valid);
      if (do_pop) begin
        rd_ptr <= rd_ptr + sts_pkg::ptr_t'(1);
      end
      count <= count_next;
    end
  end

endmodule

FILE: hw/rtl/shell_token_scanner_unit.sv
// Top level of the shell token scanner: input register, scanner and token queue.
// A byte passes through the input register and then the token queue before its first token is offered.
// Throughput: one byte per cycle; a byte that yields two tokens offers them on the
// output port one after the other, and the input stalls only when the four-entry token
// queue cannot take two more tokens.
// Reset (rst, synchronous): empties the input register and queue, restarts at row 1, column 1.
module shell_token_scanner_unit (
  input  logic        clk,
  input  logic        rst,
  sts_byte_if.sink    text,
  sts_token_if.source tokens
);

  logic               in_valid;
  logic [7:0]         in_byte;
  logic               room;
  logic               fire;
  sts_pkg::tok_slot_t res_a, res_b;
  sts_pkg::tok_slot_t push_a, push_b;
  logic               head_valid;
  sts_pkg::tok_t      head;

  // Process the held byte when the queue has room for two tokens
  assign fire       = in_valid && room;
  assign text.ready = !in_valid || fire;

  // Hold one byte between the input port and the scanner
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (text.ready) begin
      in_valid <= text.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (text.valid && text.ready) begin
      in_byte <= text.text_byte;
    end
  end

  sts_lexer u_lexer (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .byte_in (in_byte),
    .res_a   (res_a),
    .res_b   (res_b)
  );

  // Drop results of cycles that do not process a byte
  always_comb begin
    push_a       = res_a;
    push_b       = res_b;
    push_a.valid = res_a.valid && fire;
    push_b.valid = res_b.valid && fire;
  end

  sts_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_a     (push_a),
    .push_b     (push_b),
    .room       (room),
    .head_valid (head_valid),
    .head       (head),
    .pop        (tokens.ready)
  );

  assign tokens.valid        = head_valid;
  assign tokens.token_kind   = head.kind;
  assign tokens.span_start   = head.span_start;
  assign tokens.span_end     = head.span_end;
  assign tokens.start_row    = head.start_row;
  assign tokens.start_column = head.start_column;
  assign tokens.last_of_run  = head.last;

endmodule

FILE: hw/rtl/sts_checker.sv
// Port-level checks for the shell token scanner, bound to the top level.
module sts_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [4:0]  token_kind,
  input logic [15:0] span_start,
  input logic [15:0] span_end,
  input logic [15:0] start_row,
  input logic [15:0] start_column
);

  // A stalled token stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("token dropped while stalled");

  // Reset empties the token queue
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("token offered right after reset");

  // A token never ends before it starts
  a_span_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> span_end >= span_start)
    else $error("token span ends before its start");

  // Rows and columns count from one
  a_pos_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (start_row != 16'd0) && (start_column != 16'd0))
    else $error("token row or column is zero");

  // Only defined token kinds leave the block
  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> token_kind <= sts_pkg::TK_GREAT)
    else $error("undefined token kind");

endmodule

bind shell_token_scanner_unit sts_checker u_sts_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (tokens.valid),
  .out_ready    (tokens.ready),
  .token_kind   (tokens.token_kind),
  .span_start   (tokens.span_start),
  .span_end     (tokens.span_end),
  .start_row    (tokens.start_row),
  .start_column (tokens.start_column)
);

FILE: tb/shell_token_scanner_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the shell token scanner: directed script, then random text.
module shell_token_scanner_unit_tb;

  typedef struct packed {
    logic [7:0]    ch;
    logic          typed;
    sts_pkg::tok_t tok;
  } script_row_t;

  localparam sts_pkg::tok_t NO_TOK = '0;
  localparam int SCRIPT_LEN   = 36;
  localparam int RANDOM_ITEMS = 1100;
  localparam int DRAIN_EVERY  = 400;

  logic clk;
  logic rst;

  sts_byte_if  text ();
  sts_token_if tokens ();

  shell_token_scanner_unit dut (
    .clk   (clk),
    .rst   (rst),
    .text  (text),
    .tokens(tokens)
  );

  // Scanner state mirrored by the predictor
  sts_pkg::pend_t sc_pend;
  logic [7:0]     sc_first_op;
  sts_pkg::pos_t  tok_off, tok_row, tok_col;
  sts_pkg::pos_t  cur_off, cur_row, cur_col;

  sts_pkg::tok_t step_tokens[$];
  sts_pkg::tok_t expected_tokens[$];

  int         mismatches = 0;
  int         burst_left = 0;
  logic [7:0] rx_pattern = 8'hFF;
  logic [2:0] rx_slot    = 3'd0;

  string redir_ops [13] = '{"&&", "||", "<<", "<<-", ">>", "<&", ">&", "<>", ">|",
                            "|", "&", "<", ">"};

  // Directed script; typed rows carry their token, the rest go through the predictor
  script_row_t script [SCRIPT_LEN] = '{
    '{sts_pkg::CH_NL,     1'b1, '{sts_pkg::TK_NEWLINE, 16'd0, 16'd1, 16'd1, 16'd1, 1'b1}},
    '{sts_pkg::CH_SEMI,   1'b1, '{sts_pkg::TK_SEMI,    16'd1, 16'd2, 16'd2, 16'd1, 1'b1}},
    '{sts_pkg::CH_LPAREN, 1'b1, '{sts_pkg::TK_LPAREN,  16'd2, 16'd3, 16'd2, 16'd2, 1'b1}},
    '{sts_pkg::CH_RPAREN, 1'b1, '{sts_pkg::TK_RPAREN,  16'd3, 16'd4, 16'd2, 16'd3, 1'b1}},
    '{8'hFF,              1'b1, '{sts_pkg::TK_WORD,    16'd4, 16'd5, 16'd2, 16'd4, 1'b1}},
    '{sts_pkg::CH_UNDER,  1'b0, NO_TOK},
    '{sts_pkg::CH_EQ,     1'b0, NO_TOK},
    '{sts_pkg::CH_NINE,   1'b0, NO_TOK},
    '{sts_pkg::CH_LT,     1'b0, NO_TOK},
    '{sts_pkg::CH_LT,     1'b0, NO_TOK},
    '{sts_pkg::CH_MINUS,  1'b0, NO_TOK},
    '{sts_pkg::CH_AMP,    1'b0, NO_TOK},
    '{sts_pkg::CH_AMP,    1'b0, NO_TOK},
    '{sts_pkg::CH_PIPE,   1'b0, NO_TOK},
    '{sts_pkg::CH_PIPE,   1'b0, NO_TOK},
    '{sts_pkg::CH_GT,     1'b0, NO_TOK},
    '{sts_pkg::CH_GT,     1'b0, NO_TOK},
    '{sts_pkg::CH_LT,     1'b0, NO_TOK},
    '{sts_pkg::CH_AMP,    1'b0, NO_TOK},
    '{sts_pkg::CH_GT,     1'b0, NO_TOK},
    '{sts_pkg::CH_AMP,    1'b0, NO_TOK},
    '{sts_pkg::CH_LT,     1'b0, NO_TOK},
    '{sts_pkg::CH_GT,     1'b0, NO_TOK},
    '{sts_pkg::CH_GT,     1'b0, NO_TOK},
    '{sts_pkg::CH_PIPE,   1'b0, NO_TOK},
    '{sts_pkg::CH_PIPE,   1'b0, NO_TOK},
    '{sts_pkg::CH_AMP,    1'b0, NO_TOK},
    '{sts_pkg::CH_LT,     1'b0, NO_TOK},
    '{sts_pkg::CH_LT,     1'b0, NO_TOK},
    '{sts_pkg::CH_GT,     1'b0, NO_TOK},
    '{sts_pkg::CH_ZERO,   1'b0, NO_TOK},
    '{sts_pkg::CH_TAB,    1'b0, NO_TOK},
    '{sts_pkg::CH_LT,     1'b0, NO_TOK},
    '{sts_pkg::CH_NUL,    1'b0, NO_TOK},
    '{sts_pkg::CH_NL,     1'b1, '{sts_pkg::TK_NEWLINE, 16'd0, 16'd1, 16'd1, 16'd1, 1'b1}},
    '{sts_pkg::CH_NUL,    1'b0, NO_TOK}
  };

  // Free-running clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Advance a saturating position count, holding it at its maximum
  function automatic sts_pkg::pos_t bump(input sts_pkg::pos_t v);
    return (v == sts_pkg::POS_MAX) ? v : v + sts_pkg::POS_ONE;
  endfunction

  function automatic bit is_letter(input logic [7:0] c);
    return ((c >= sts_pkg::CH_LOW_A) && (c <= sts_pkg::CH_LOW_Z)) ||
           ((c >= sts_pkg::CH_UP_A) && (c <= sts_pkg::CH_UP_Z));
  endfunction

  function automatic bit is_numeral(input logic [7:0] c);
    return (c >= sts_pkg::CH_ZERO) && (c <= sts_pkg::CH_NINE);
  endfunction

  // Return to offset 0, row 1, column 1 with nothing pending
  function automatic void restart_position();
    sc_pend     = sts_pkg::PEND_NONE;
    sc_first_op = sts_pkg::CH_NUL;
    tok_off     = '0;
    tok_row     = sts_pkg::POS_ONE;
    tok_col     = sts_pkg::POS_ONE;
    cur_off     = '0;
    cur_row     = sts_pkg::POS_ONE;
    cur_col     = sts_pkg::POS_ONE;
  endfunction

  // Advance the cursor past one byte
  function automatic void advance_position(input logic [7:0] c);
    cur_off = bump(cur_off);
    if (c == sts_pkg::CH_NL) begin
      cur_row = bump(cur_row);
      cur_col = sts_pkg::POS_ONE;
    end else begin
      cur_col = bump(cur_col);
    end
  endfunction

  // Emit a token spanning from its start to the cursor
  function automatic void close_token(input sts_pkg::kind_t k);
    sts_pkg::tok_t t;
    t.kind         = k;
    t.span_start   = tok_off;
    t.span_end     = cur_off;
    t.start_row    = tok_row;
    t.start_column = tok_col;
    t.last         = 1'b0;
    step_tokens.push_back(t);
    sc_pend = sts_pkg::PEND_NONE;
  endfunction

  // Begin a token on a byte with nothing pending
  function automatic void start_token(input logic [7:0] c);
    if ((c == sts_pkg::CH_SPACE) || (c == sts_pkg::CH_TAB) || (c == sts_pkg::CH_CR)) begin
      advance_position(c);
      return;
    end
    tok_off = cur_off;
    tok_row = cur_row;
    tok_col = cur_col;
    advance_position(c);
    if (c == sts_pkg::CH_NL) begin
      close_token(sts_pkg::TK_NEWLINE);
    end else if (is_letter(c) || (c == sts_pkg::CH_UNDER)) begin
      sc_pend = sts_pkg::PEND_NAME;
    end else if (is_numeral(c)) begin
      sc_pend = sts_pkg::PEND_DIGITS;
    end else if ((c == sts_pkg::CH_PIPE) || (c == sts_pkg::CH_AMP) ||
                 (c == sts_pkg::CH_LT) || (c == sts_pkg::CH_GT)) begin
      sc_pend     = sts_pkg::PEND_OP;
      sc_first_op = c;
    end else if (c == sts_pkg::CH_SEMI) begin
      close_token(sts_pkg::TK_SEMI);
    end else if (c == sts_pkg::CH_LPAREN) begin
      close_token(sts_pkg::TK_LPAREN);
    end else if (c == sts_pkg::CH_RPAREN) begin
      close_token(sts_pkg::TK_RPAREN);
    end else begin
      close_token(sts_pkg::TK_WORD);
    end
  endfunction

  // Feed a byte to the pending token; return 1 when the token absorbs it
  function automatic bit extend_token(input logic [7:0] c);
    sts_pkg::kind_t k;
    bit             found;
    k     = sts_pkg::TK_WORD;
    found = 1'b1;
    case (sc_pend)
      sts_pkg::PEND_NAME: begin
        if (is_letter(c) || is_numeral(c) || (c == sts_pkg::CH_UNDER)) begin
          advance_position(c);
          return 1'b1;
        end
        close_token((c == sts_pkg::CH_EQ) ? sts_pkg::TK_ASSIGN : sts_pkg::TK_WORD);
        return 1'b0;
      end
      sts_pkg::PEND_DIGITS: begin
        if (is_numeral(c)) begin
          advance_position(c);
          return 1'b1;
        end
        close_token(((c == sts_pkg::CH_LT) || (c == sts_pkg::CH_GT)) ? sts_pkg::TK_IONUM
                                                                      : sts_pkg::TK_WORD);
        return 1'b0;
      end
      sts_pkg::PEND_OP: begin
        case ({sc_first_op, c})
          {sts_pkg::CH_AMP, sts_pkg::CH_AMP}:   k = sts_pkg::TK_AND_IF;
          {sts_pkg::CH_PIPE, sts_pkg::CH_PIPE}: k = sts_pkg::TK_OR_IF;
          {sts_pkg::CH_LT, sts_pkg::CH_LT}:     k = sts_pkg::TK_DLESS;
          {sts_pkg::CH_GT, sts_pkg::CH_GT}:     k = sts_pkg::TK_DGREAT;
          {sts_pkg::CH_LT, sts_pkg::CH_AMP}:    k = sts_pkg::TK_LESSAND;
          {sts_pkg::CH_GT, sts_pkg::CH_AMP}:    k = sts_pkg::TK_GREATAND;
          {sts_pkg::CH_LT, sts_pkg::CH_GT}:     k = sts_pkg::TK_LESSGREAT;
          {sts_pkg::CH_GT, sts_pkg::CH_PIPE}:   k = sts_pkg::TK_CLOBBER;
          default:                              found = 1'b0;
        endcase
        if (!found) begin
          case (sc_first_op)
            sts_pkg::CH_PIPE: k = sts_pkg::TK_PIPE;
            sts_pkg::CH_AMP:  k = sts_pkg::TK_AMP;
            sts_pkg::CH_LT:   k = sts_pkg::TK_LESS;
            sts_pkg::CH_GT:   k = sts_pkg::TK_GREAT;
            default:          k = sts_pkg::TK_WORD;
          endcase
          close_token(k);
          return 1'b0;
        end
        advance_position(c);
        if (k == sts_pkg::TK_DLESS) begin
          sc_pend = sts_pkg::PEND_DLESS;
        end else begin
          close_token(k);
        end
        return 1'b1;
      end
      sts_pkg::PEND_DLESS: begin
        if (c == sts_pkg::CH_MINUS) begin
          advance_position(c);
          close_token(sts_pkg::TK_DLESSDASH);
          return 1'b1;
        end
        close_token(sts_pkg::TK_DLESS);
        return 1'b0;
      end
      default: begin
        sc_pend = sts_pkg::PEND_NONE;
        return 1'b0;
      end
    endcase
  endfunction

  // Work out the tokens one accepted byte produces
  function automatic void scan_byte(input logic [7:0] c);
    bit used;
    used = 1'b0;
    step_tokens.delete();
    if (sc_pend != sts_pkg::PEND_NONE) used = extend_token(c);
    if (c == sts_pkg::CH_NUL) begin
      restart_position();
    end else if (!used) begin
      start_token(c);
    end
  endfunction

  function automatic logic [7:0] pick_name_byte(input bit lead);
    int r;
    r = $urandom_range(0, lead ? 52 : 62);
    if (r < 26) return 8'(sts_pkg::CH_LOW_A + r);
    if (r < 52) return 8'(sts_pkg::CH_UP_A + r - 26);
    if (r == 52) return sts_pkg::CH_UNDER;
    return 8'(sts_pkg::CH_ZERO + r - 53);
  endfunction

  task automatic note_mismatch(input string what);
    mismatches++;
    $display("%0t ns: token mismatch: %s", $time, what);
  endtask

  // Transfer one byte, idling between bursts, and queue its tokens
  task automatic send_byte(input logic [7:0] c, input logic typed,
                           input sts_pkg::tok_t typed_tok);
    sts_pkg::tok_t t;
    if (burst_left == 0) begin
      text.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 150)
                                                : $urandom_range(1, 24);
    end
    text.valid     <= 1'b1;
    text.text_byte <= c;
    @(posedge clk);
    while (!text.ready) @(posedge clk);
    scan_byte(c);
    if (typed) begin
      expected_tokens.push_back(typed_tok);
    end else begin
      foreach (step_tokens[i]) begin
        t      = step_tokens[i];
        t.last = (i == step_tokens.size() - 1);
        expected_tokens.push_back(t);
      end
    end
    if (burst_left > 0) burst_left--;
  endtask

  // Drop valid and hold until every queued token has come out
  task automatic drain_tokens();
    text.valid <= 1'b0;
    @(posedge clk);
    while (expected_tokens.size() != 0) @(posedge clk);
  endtask

  // Compare one transferred token with the oldest expectation
  task automatic check_token();
    sts_pkg::tok_t want;
    if (expected_tokens.size() == 0) begin
      note_mismatch($sformatf("kind %0d at offset %0d with nothing expected",
                              tokens.token_kind, tokens.span_start));
      return;
    end
    want = expected_tokens.pop_front();
    if (tokens.token_kind !== want.kind)
      note_mismatch($sformatf("kind %0d, want %0d", tokens.token_kind, want.kind));
    if (tokens.span_start !== want.span_start)
      note_mismatch($sformatf("span_start %0d, want %0d", tokens.span_start, want.span_start));
    if (tokens.span_end !== want.span_end)
      note_mismatch($sformatf("span_end %0d, want %0d", tokens.span_end, want.span_end));
    if (tokens.start_row !== want.start_row)
      note_mismatch($sformatf("start_row %0d, want %0d", tokens.start_row, want.start_row));
    if (tokens.start_column !== want.start_column)
      note_mismatch($sformatf("start_column %0d, want %0d", tokens.start_column,
                              want.start_column));
    if (tokens.last_of_run !== want.last)
      note_mismatch($sformatf("last_of_run %0b, want %0b", tokens.last_of_run, want.last));
  endtask

  // Check each token transfer and stall on an eight-bit ready pattern refreshed at random
  always @(posedge clk) begin
    if (!rst && tokens.valid && tokens.ready) check_token();
    if (rx_slot == 3'd0) begin
      if ($urandom_range(0, 3) == 0) begin
        rx_pattern = 8'hFF;
      end else begin
        rx_pattern = 8'($urandom) | 8'h01;
      end
    end
    tokens.ready <= rx_pattern[rx_slot];
    rx_slot = rx_slot + 3'd1;
  end

  // Stimulus
  initial begin
    int         sent;
    int         r;
    string      op;
    logic [7:0] frag[$];
    sent = 0;
    rst            <= 1'b1;
    text.valid     <= 1'b0;
    text.text_byte <= sts_pkg::CH_NUL;
    restart_position();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed script, then wait for every token
    foreach (script[i]) send_byte(script[i].ch, script[i].typed, script[i].tok);
    drain_tokens();

    // Random shell-like text: names, assignments, io numbers, operators, noise
    while (sent < RANDOM_ITEMS) begin
      frag.delete();
      r = $urandom_range(0, 99);
      if (r < 25) begin
        frag.push_back(pick_name_byte(1'b1));
        repeat ($urandom_range(0, 6)) frag.push_back(pick_name_byte(1'b0));
        if ($urandom_range(0, 2) == 0) begin
          frag.push_back(sts_pkg::CH_EQ);
          repeat ($urandom_range(0, 4)) frag.push_back(pick_name_byte(1'b0));
        end
      end else if (r < 40) begin
        repeat ($urandom_range(1, 4))
          frag.push_back(8'(sts_pkg::CH_ZERO + $urandom_range(0, 9)));
        if ($urandom_range(0, 1) == 1)
          frag.push_back(($urandom_range(0, 1) == 1) ? sts_pkg::CH_LT : sts_pkg::CH_GT);
      end else if (r < 60) begin
        op = redir_ops[$urandom_range(0, 12)];
        for (int k = 0; k < op.len(); k++) frag.push_back(op[k]);
      end else if (r < 70) begin
        case ($urandom_range(0, 3))
          0:       frag.push_back(sts_pkg::CH_NL);
          1:       frag.push_back(sts_pkg::CH_SEMI);
          2:       frag.push_back(sts_pkg::CH_LPAREN);
          default: frag.push_back(sts_pkg::CH_RPAREN);
        endcase
      end else if (r < 82) begin
        repeat ($urandom_range(1, 3)) begin
          case ($urandom_range(0, 2))
            0:       frag.push_back(sts_pkg::CH_SPACE);
            1:       frag.push_back(sts_pkg::CH_TAB);
            default: frag.push_back(sts_pkg::CH_CR);
          endcase
        end
      end else if (r < 87) begin
        frag.push_back(sts_pkg::CH_NUL);
      end else begin
        frag.push_back(8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 2) == 0) frag.push_back(sts_pkg::CH_SPACE);
      foreach (frag[j]) begin
        send_byte(frag[j], 1'b0, NO_TOK);
        sent++;
        if ((sent % DRAIN_EVERY) == 0) drain_tokens();
      end
    end

    // Flush any pending token, then let the pipeline settle
    send_byte(sts_pkg::CH_NUL, 1'b0, NO_TOK);
    drain_tokens();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
